[design/display_animation_sequencer_defines.svh]
// Assertion macros for the display animation sequencer.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef DISPLAY_ANIMATION_SEQUENCER_DEFINES_SVH
`define DISPLAY_ANIMATION_SEQUENCER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define DAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("display_animation_sequencer: assertion failed");
// next-cycle implication
`define DAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("display_animation_sequencer: assertion failed");
`else
`define DAS_ASSERT_NOW(label, ante, cons)
`define DAS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[design/das_pkg.sv]
// Shared constants, codes and helpers for the display animation sequencer.
// No dependencies.
package das_pkg;

  localparam int NUM_DISPLAYS  = 8;
  localparam int FRAME_ENTRIES = 1024;
  localparam int CMD_LEN       = 6;

  localparam int TBL_AW     = $clog2(FRAME_ENTRIES);
  localparam int DISP_W     = (NUM_DISPLAYS > 1) ? $clog2(NUM_DISPLAYS) : 1;
  localparam int CMD_FILL_W = $clog2(CMD_LEN + 1);

  localparam logic [15:0] NO_FRAME   = 16'hFFFF;
  localparam logic [15:0] HOLD_DELAY = 16'hFFFF;

  localparam logic [7:0] CMD_START_MASK = 8'hC0;
  localparam logic [7:0] CMD_START_CODE = 8'h80;
  localparam logic [7:0] CMD_TYPE_MASK  = 8'h3F;
  localparam logic [7:0] CMD_QUEUE      = 8'd1;
  localparam logic [7:0] CMD_JUMP       = 8'd3;

  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_TABLE = 2'd2;

  localparam logic [3:0] ACTIVE_RESET = 4'd8;

  function automatic logic frame_ok(input logic [15:0] f);
    frame_ok = (f != NO_FRAME) && (32'(f) < FRAME_ENTRIES);
  endfunction

endpackage

[design/display_animation_sequencer.sv]
// Display animation sequencer: per-display frame walker over a linked frame table,
// driven by serial command bytes and ticks. Uses das_pkg and the defines header.
//
// Channels: in_* carries one beat per item (tuser = mode; tdata = rx_byte,
// table_index, table_delay, table_next). out_* carries one beat per active
// display after a tick, tlast on the last one. cfg_* writes active_displays.
// Steps: a table write, mode 3 and most command bytes are handled as they are
// accepted. A tick then works through each active display in turn: count the
// delay, then frame table reads (next link, then the new frame's delay, at
// most two reads over the single read port), load the queued animation where
// needed and hand the beat to the output register. A jump command (type 3)
// steps through all NUM_DISPLAYS displays, one table read per display.
// in_tready is high only while no item is being worked on.
// Reset: all frames invalid, delays zero, command parser idle, active count 8.
// The frame table is not cleared; entries must be written before use.
// A stalled receiver holds the current out beat and the walk waits behind it.
`include "display_animation_sequencer_defines.svh"

module display_animation_sequencer
  import das_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // rx_byte[7:0], table_index[17:8],
                                  // table_delay[33:18], table_next[49:34]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // display_id[2:0], frame_index[18:3]
  output logic [0:0]  out_tuser,  // frame_valid[0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data    // active_displays[3:0]
);

  typedef enum logic [2:0] {
    S_IDLE, S_JMP_RD, S_JMP_WB, S_T_DEC, S_T_NEXT, S_T_LOAD, S_T_DLY, S_REPORT
  } state_t;

  state_t state_r;

  // frame table: {next, delay}
  logic [31:0]       tbl_mem [FRAME_ENTRIES];
  logic [31:0]       tbl_rd_r;
  logic [TBL_AW-1:0] tbl_raddr;
  logic              tbl_we;

  logic [15:0] cur_frame_r [NUM_DISPLAYS];
  logic [15:0] end_frame_r [NUM_DISPLAYS];
  logic [15:0] delay_r     [NUM_DISPLAYS];
  logic [15:0] q_frame_r   [NUM_DISPLAYS];
  logic [15:0] q_end_r     [NUM_DISPLAYS];

  logic                  cmd_busy_r;
  logic [CMD_FILL_W-1:0] cmd_fill_r;
  logic [7:0]            cmd_bytes_r [CMD_LEN];

  logic [3:0]        active_r;
  logic [DISP_W-1:0] disp_r;
  logic [DISP_W-1:0] last_idx;

  logic        out_valid_r;
  logic [2:0]  out_id_r;
  logic [15:0] out_frame_r;
  logic        out_fvalid_r;
  logic        out_last_r;

  logic       in_acc;
  logic [1:0] in_mode;
  logic [7:0] in_byte;

  logic [15:0] cur_sel, end_sel, dly_sel, qf_sel, qe_sel;
  logic [15:0] dly_dec;
  logic [15:0] rd_next;
  logic        out_free;

  // command parser
  logic                  cmd_live;
  logic                  cmd_busy_nxt;
  logic [CMD_FILL_W-1:0] cmd_fill_nxt;
  logic                  cmd_store;
  logic [7:0]            cmd_type;
  logic                  q_we;
  logic [7:0]            q_idx;
  logic [15:0]           q_start, q_end;
  logic                  jump_go;
  logic [4:0]            act_ext;

  assign in_mode   = in_tuser;
  assign in_byte   = in_tdata[7:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign cur_sel = cur_frame_r[disp_r];
  assign end_sel = end_frame_r[disp_r];
  assign dly_sel = delay_r[disp_r];
  assign qf_sel  = q_frame_r[disp_r];
  assign qe_sel  = q_end_r[disp_r];
  assign rd_next = tbl_rd_r[31:16];
  assign dly_dec = (dly_sel != 16'd0 && dly_sel != HOLD_DELAY) ? dly_sel - 16'd1 : dly_sel;
  assign out_free = !out_valid_r || out_tready;

  // active count clamped to 1..NUM_DISPLAYS
  always_comb begin
    act_ext = {1'b0, active_r};
    if (act_ext == 5'd0) begin
      act_ext = 5'd1;
    end else if (act_ext > 5'(NUM_DISPLAYS)) begin
      act_ext = 5'(NUM_DISPLAYS);
    end
    last_idx = DISP_W'(act_ext - 5'd1);
  end

  always_comb begin
    cmd_live     = cmd_busy_r ||
                   ((in_byte & CMD_START_MASK) == CMD_START_CODE);
    cmd_busy_nxt = cmd_busy_r;
    cmd_fill_nxt = cmd_fill_r;
    cmd_store    = 1'b0;
    q_we         = 1'b0;
    jump_go      = 1'b0;
    q_idx        = cmd_bytes_r[1];
    q_start      = {cmd_bytes_r[3], cmd_bytes_r[2]};
    q_end        = {in_byte, cmd_bytes_r[4]};
    cmd_type     = ((cmd_fill_r == '0) ? in_byte : cmd_bytes_r[0]) & CMD_TYPE_MASK;
    if (cmd_live) begin
      if (cmd_fill_r >= CMD_FILL_W'(CMD_LEN)) begin
        // overflow: drop byte, abandon command
        cmd_busy_nxt = 1'b0;
        cmd_fill_nxt = '0;
      end else begin
        cmd_store    = 1'b1;
        cmd_busy_nxt = 1'b1;
        cmd_fill_nxt = cmd_fill_r + CMD_FILL_W'(1);
        case (cmd_type)
          CMD_QUEUE: begin
            if (cmd_fill_nxt == CMD_FILL_W'(CMD_LEN)) begin
              q_we         = (32'(q_idx) < NUM_DISPLAYS);
              cmd_busy_nxt = 1'b0;
              cmd_fill_nxt = '0;
            end
          end
          CMD_JUMP: begin
            jump_go      = 1'b1;
            cmd_busy_nxt = 1'b0;
            cmd_fill_nxt = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (state_r)
      S_JMP_RD: tbl_raddr = TBL_AW'(end_sel);
      S_T_NEXT: tbl_raddr = TBL_AW'(rd_next);
      S_T_LOAD: tbl_raddr = TBL_AW'(qf_sel);
      default:  tbl_raddr = TBL_AW'(cur_sel);
    endcase
  end

  assign tbl_we = in_acc && (in_mode == MODE_TABLE) &&
                  (32'(in_tdata[17:8]) < FRAME_ENTRIES);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[TBL_AW'(in_tdata[17:8])] <= {in_tdata[49:34], in_tdata[33:18]};
    end
    tbl_rd_r <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      disp_r      <= '0;
      cmd_busy_r  <= 1'b0;
      cmd_fill_r  <= '0;
      active_r    <= ACTIVE_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_DISPLAYS; i++) begin
        cur_frame_r[i] <= NO_FRAME;
        end_frame_r[i] <= NO_FRAME;
        q_frame_r[i]   <= NO_FRAME;
        q_end_r[i]     <= NO_FRAME;
        delay_r[i]     <= 16'd0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
      // S_REPORT loads the next beat itself when the register frees up
      if (out_valid_r && out_tready && state_r != S_REPORT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_mode == MODE_BYTE) begin
            cmd_busy_r <= cmd_busy_nxt;
            cmd_fill_r <= cmd_fill_nxt;
            if (cmd_store) begin
              cmd_bytes_r[cmd_fill_r] <= in_byte;
            end
            if (q_we) begin
              q_frame_r[DISP_W'(q_idx)] <= q_start;
              q_end_r[DISP_W'(q_idx)]   <= q_end;
            end
            if (jump_go) begin
              disp_r  <= '0;
              state_r <= S_JMP_RD;
            end
          end else if (in_acc && in_mode == MODE_TICK) begin
            disp_r  <= '0;
            state_r <= S_T_DEC;
          end
        end
        S_JMP_RD: begin
          cur_frame_r[disp_r] <= end_sel;
          state_r             <= S_JMP_WB;
        end
        S_JMP_WB: begin
          delay_r[disp_r] <= frame_ok(cur_sel) ? tbl_rd_r[15:0] : 16'd0;
          disp_r          <= disp_r + DISP_W'(1);
          if (disp_r == DISP_W'(NUM_DISPLAYS - 1)) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= S_JMP_RD;
          end
        end
        S_T_DEC: begin
          delay_r[disp_r] <= dly_dec;
          if (dly_dec != 16'd0) begin
            state_r <= S_REPORT;
          end else if (frame_ok(cur_sel)) begin
            state_r <= S_T_NEXT;
          end else begin
            state_r <= S_T_LOAD;
          end
        end
        S_T_NEXT: begin
          // table read of the current frame is back: follow the link
          cur_frame_r[disp_r] <= rd_next;
          if (frame_ok(rd_next)) begin
            state_r <= S_T_DLY;
          end else begin
            state_r <= S_T_LOAD;
          end
        end
        S_T_LOAD: begin
          cur_frame_r[disp_r] <= qf_sel;
          end_frame_r[disp_r] <= qe_sel;
          state_r             <= S_T_DLY;
        end
        S_T_DLY: begin
          delay_r[disp_r] <= frame_ok(cur_sel) ? tbl_rd_r[15:0] : 16'd0;
          state_r         <= S_REPORT;
        end
        S_REPORT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_id_r     <= 3'(disp_r);
            out_frame_r  <= cur_sel;
            out_fvalid_r <= frame_ok(cur_sel);
            out_last_r   <= (disp_r == last_idx);
            if (disp_r == last_idx) begin
              state_r <= S_IDLE;
            end else begin
              disp_r  <= disp_r + DISP_W'(1);
              state_r <= S_T_DEC;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_frame_r, out_id_r};
  assign out_tuser  = out_fvalid_r;
  assign out_tlast  = out_last_r;

  `DAS_ASSERT_NOW(a_fill_bound, 1'b1, cmd_fill_r <= CMD_FILL_W'(CMD_LEN))
  `DAS_ASSERT_NOW(a_idle_parser, !cmd_busy_r, cmd_fill_r == '0)
  `DAS_ASSERT_NOW(a_last_id, out_tvalid && out_tlast, out_tdata[2:0] == 3'(last_idx))
  `DAS_ASSERT_NOW(a_valid_range, out_tvalid && out_tuser[0],
                  32'(out_tdata[18:3]) < FRAME_ENTRIES)
  `DAS_ASSERT_NEXT(a_tick_busy, in_tvalid && in_tready && in_tuser == MODE_TICK, !in_tready)

endmodule
